>>> rtl/clt_pkg.sv
// Package for the client liveness table: widths, result codes, register indexes,
// micro-op and step encodings, and the control program of the sequencer.
// No dependencies; used by every module of the block.
package clt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths.
  localparam int ID_W     = 32;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int ACT_W    = 3;
  localparam int POS_W    = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Configuration registers.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OFFLINE = CFG_IDX_W'(1);
  localparam logic [TIME_W-1:0]   TIMEOUT_RESET = TIME_W'(35);
  localparam logic [STATUS_W-1:0] OFFLINE_RESET = STATUS_W'(6);

  // Result actions.
  localparam logic [ACT_W-1:0] ACT_ADDED   = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_UPDATED = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_OFFLINE = ACT_W'(2);
  localparam logic [ACT_W-1:0] ACT_STALE   = ACT_W'(3);
  localparam logic [ACT_W-1:0] ACT_FULL    = ACT_W'(4);

  // Program steps.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_NEW,
    S_KNOWN,
    S_AGE,
    S_ACHK,
    S_ATEST,
    S_EMIT,
    S_FLUSH
  } step_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_IDX_END,
    C_MATCH,
    C_FULL,
    C_OFFLINE,
    C_STALE,
    C_OUT_FREE
  } cond_t;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INC_IDX,
    OP_CLR_IDX,
    OP_PEND_FULL,
    OP_APPEND,
    OP_DROP_HIT,
    OP_REFRESH,
    OP_PUSH_STALE,
    OP_PUSH_LAST
  } op_t;

  // One control word of the program.
  typedef struct packed {
    cond_t cond;
    step_t jt;
    step_t jf;
    op_t   op_t_sel;
    op_t   op_f_sel;
    logic  in_rdy;
  } ucw_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic idx_end;
    logic match;
    logic full;
    logic offline;
    logic stale;
    logic out_free;
  } dp_flags_t;

  // Control program: condition, jump targets, and the operation on each branch.
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    unique case (s)
      S_IDLE:   w = '{C_IN_VALID, S_SEARCH, S_IDLE,   OP_LOAD,       OP_NONE,    1'b1};
      S_SEARCH: w = '{C_IDX_END,  S_NEW,    S_CMP,    OP_NONE,       OP_NONE,    1'b0};
      S_CMP:    w = '{C_MATCH,    S_KNOWN,  S_SEARCH, OP_NONE,       OP_INC_IDX, 1'b0};
      S_NEW:    w = '{C_FULL,     S_AGE,    S_AGE,    OP_PEND_FULL,  OP_APPEND,  1'b0};
      S_KNOWN:  w = '{C_OFFLINE,  S_AGE,    S_AGE,    OP_DROP_HIT,   OP_REFRESH, 1'b0};
      S_AGE:    w = '{C_ALWAYS,   S_ACHK,   S_ACHK,   OP_CLR_IDX,    OP_NONE,    1'b0};
      S_ACHK:   w = '{C_IDX_END,  S_FLUSH,  S_ATEST,  OP_NONE,       OP_NONE,    1'b0};
      S_ATEST:  w = '{C_STALE,    S_EMIT,   S_ACHK,   OP_NONE,       OP_INC_IDX, 1'b0};
      S_EMIT:   w = '{C_OUT_FREE, S_ACHK,   S_EMIT,   OP_PUSH_STALE, OP_NONE,    1'b0};
      S_FLUSH:  w = '{C_OUT_FREE, S_IDLE,   S_FLUSH,  OP_PUSH_LAST,  OP_NONE,    1'b0};
      default:  w = '{C_ALWAYS,   S_IDLE,   S_IDLE,   OP_NONE,       OP_NONE,    1'b0};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/clt_useq.sv
// Microcode sequencer of the client liveness table: step counter, program
// lookup and conditional jumps. Depends on clt_pkg.
module clt_useq (
  input  logic               clk,
  input  logic               rst,
  input  clt_pkg::dp_flags_t flags,
  output clt_pkg::op_t       op,
  output logic               in_ready
);
  import clt_pkg::*;

  step_t upc;
  step_t upc_next;
  ucw_t  ctrl;
  logic  taken;

  // Current control word and its selected condition.
  always_comb begin
    ctrl = ucode(upc);
    unique case (ctrl.cond)
      C_ALWAYS:   taken = 1'b1;
      C_IN_VALID: taken = flags.in_valid;
      C_IDX_END:  taken = flags.idx_end;
      C_MATCH:    taken = flags.match;
      C_FULL:     taken = flags.full;
      C_OFFLINE:  taken = flags.offline;
      C_STALE:    taken = flags.stale;
      C_OUT_FREE: taken = flags.out_free;
      default:    taken = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    upc_next = taken ? ctrl.jt : ctrl.jf;
  end

  // Outputs to the datapath and the input channel.
  always_comb begin
    op       = taken ? ctrl.op_t_sel : ctrl.op_f_sel;
    in_ready = ctrl.in_rdy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // Items are taken only at the idle step.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> upc == S_IDLE)
    else $error("input ready outside the idle step");

  // An accepted item always starts the search.
  a_load_search: assert property (@(posedge clk) disable iff (rst)
    (in_ready && flags.in_valid) |=> upc == S_SEARCH)
    else $error("accepted item did not start the search");

  // The flush step leaves only once the final result is pushed.
  a_flush_exit: assert property (@(posedge clk) disable iff (rst)
    (upc == S_FLUSH && !flags.out_free) |=> upc == S_FLUSH)
    else $error("flush left while output was blocked");

endmodule

>>> rtl/clt_datapath.sv
// Datapath of the client liveness table: entry arrays with parallel
// compaction, scan pointer, pending result and output register. Depends on clt_pkg.
module clt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  clt_pkg::op_t                  op,
  input  logic                          in_valid,
  input  logic [clt_pkg::ID_W-1:0]      client_id,
  input  logic [clt_pkg::STATUS_W-1:0]  client_status,
  input  logic [clt_pkg::TIME_W-1:0]    now_time,
  input  logic [clt_pkg::TIME_W-1:0]    timeout_seconds,
  input  logic [clt_pkg::STATUS_W-1:0]  offline_status,
  output clt_pkg::dp_flags_t            flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [clt_pkg::ACT_W-1:0]     action,
  output logic [clt_pkg::POS_W-1:0]     position,
  output logic [clt_pkg::ID_W-1:0]      affected_id,
  output logic [clt_pkg::POS_W-1:0]     entry_count,
  output logic                          last_result,
  output logic                          table_empty
);
  import clt_pkg::*;

  // Table storage and count.
  logic [ID_W-1:0]   ids   [TABLE_DEPTH];
  logic [TIME_W-1:0] times [TABLE_DEPTH];
  logic [CNT_W-1:0]  cnt;

  // Captured message and scan pointer.
  logic [ID_W-1:0]     msg_id;
  logic [STATUS_W-1:0] msg_status;
  logic [TIME_W-1:0]   msg_now;
  logic [CNT_W-1:0]    idx;

  // Result waiting until it is known whether it is the final one.
  logic [ACT_W-1:0] pend_act;
  logic [POS_W-1:0] pend_pos;
  logic [ID_W-1:0]  pend_id;
  logic [CNT_W-1:0] pend_cnt;

  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_time;
  logic [TIME_W-1:0] age;
  logic [POS_W-1:0]  idx_pos;
  logic              drop;
  logic              push;

  // Entry under the scan pointer and its age.
  always_comb begin
    rd_id   = ids[idx[IDX_W-1:0]];
    rd_time = times[idx[IDX_W-1:0]];
    age     = msg_now - rd_time;
    idx_pos = POS_W'(idx) + POS_W'(1);
    drop    = (op == OP_DROP_HIT) || (op == OP_PUSH_STALE);
    push    = (op == OP_PUSH_STALE) || (op == OP_PUSH_LAST);
  end

  // Status flags for the sequencer.
  always_comb begin
    flags.in_valid = in_valid;
    flags.idx_end  = (idx == cnt);
    flags.match    = (rd_id == msg_id);
    flags.full     = (cnt == CNT_W'(TABLE_DEPTH));
    flags.offline  = (msg_status == offline_status);
    flags.stale    = (age > timeout_seconds);
    flags.out_free = !out_valid || out_ready;
  end

  // Entry arrays: append, refresh, and a parallel collapse behind the pointer.
  always_ff @(posedge clk) begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (drop && (CNT_W'(j) >= idx) && (j + 1 < TABLE_DEPTH)) begin
        ids[j]   <= ids[(j + 1) % TABLE_DEPTH];
        times[j] <= times[(j + 1) % TABLE_DEPTH];
      end else if ((op == OP_APPEND) && (cnt == CNT_W'(j))) begin
        ids[j]   <= msg_id;
        times[j] <= msg_now;
      end else if ((op == OP_REFRESH) && (idx == CNT_W'(j))) begin
        times[j] <= msg_now;
      end
    end
  end

  // Live entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (op == OP_APPEND) begin
      cnt <= cnt + CNT_W'(1);
    end else if (drop) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Message capture and scan pointer.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        msg_id     <= client_id;
        msg_status <= client_status;
        msg_now    <= now_time;
        idx        <= '0;
      end
      OP_INC_IDX: idx <= idx + CNT_W'(1);
      OP_CLR_IDX: idx <= '0;
      default: ;
    endcase
  end

  // Pending result.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_PEND_FULL: begin
        pend_act <= ACT_FULL;
        pend_pos <= '0;
        pend_id  <= msg_id;
        pend_cnt <= cnt;
      end
      OP_APPEND: begin
        pend_act <= ACT_ADDED;
        pend_pos <= POS_W'(cnt) + POS_W'(1);
        pend_id  <= msg_id;
        pend_cnt <= cnt + CNT_W'(1);
      end
      OP_DROP_HIT: begin
        pend_act <= ACT_OFFLINE;
        pend_pos <= idx_pos;
        pend_id  <= msg_id;
        pend_cnt <= cnt - CNT_W'(1);
      end
      OP_REFRESH: begin
        pend_act <= ACT_UPDATED;
        pend_pos <= idx_pos;
        pend_id  <= msg_id;
        pend_cnt <= cnt;
      end
      OP_PUSH_STALE: begin
        pend_act <= ACT_STALE;
        pend_pos <= idx_pos;
        pend_id  <= rd_id;
        pend_cnt <= cnt - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Output register: the pending result moves here when the next one exists
  // or when the item is finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      action      <= pend_act;
      position    <= pend_pos;
      affected_id <= pend_id;
      entry_count <= POS_W'(pend_cnt);
      last_result <= (op == OP_PUSH_LAST);
      table_empty <= (pend_cnt == '0);
    end
  end

  // The count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A push never overwrites a result the receiver has not taken.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || out_ready))
    else $error("result overwritten while stalled");

  // An append grows the table by one entry.
  a_append_cnt: assert property (@(posedge clk) disable iff (rst)
    (op == OP_APPEND) |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("append did not grow the table");

  // A removal shrinks the table by one entry.
  a_drop_cnt: assert property (@(posedge clk) disable iff (rst)
    drop |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("removal did not shrink the table");

endmodule

>>> rtl/client_liveness_table.sv
// Top level of the client liveness table: configuration registers, the
// microcode sequencer and the datapath. Depends on clt_pkg, clt_useq, clt_datapath.
//
// Usage: each input item is one message (client_id, client_status, now_time),
// taken on in_valid and in_ready. An unknown id is appended while there is room
// (else a full result is given), a known id with the offline status is removed
// with the table collapsing behind it, any other known id has its time refreshed;
// then every entry older than timeout_seconds is removed in table order. Each
// action gives one result item on out_valid and out_ready; last_result marks the
// final one of an item, which always has at least one and at most seventeen.
// Timing: the sequencer runs one program step a cycle. After the item is taken,
// the id search checks for the end of the table and compares each entry in turn;
// the own action and the aging setup follow. Aging tests each entry, and hands a
// removed one over with compaction. The final check and the last result close the
// item. in_ready is high only at the idle step, so the block works on one item at
// a time. A stalled receiver holds the sequencer at the step that must hand over
// a result; nothing is lost.
// Reset empties the table, returns timeout_seconds to 35 and offline_status to
// 6. Configuration writes (cfg_index 0: timeout, 1: offline status) are always
// accepted; other indexes are ignored.
module client_liveness_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [clt_pkg::ID_W-1:0]        client_id,
  input  logic [clt_pkg::STATUS_W-1:0]    client_status,
  input  logic [clt_pkg::TIME_W-1:0]      now_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [clt_pkg::ACT_W-1:0]       action,
  output logic [clt_pkg::POS_W-1:0]       position,
  output logic [clt_pkg::ID_W-1:0]        affected_id,
  output logic [clt_pkg::POS_W-1:0]       entry_count,
  output logic                            last_result,
  output logic                            table_empty,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import clt_pkg::*;

  logic [TIME_W-1:0]   timeout_seconds;
  logic [STATUS_W-1:0] offline_status;
  op_t                 op;
  dp_flags_t           flags;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TIMEOUT_RESET;
      offline_status  <= OFFLINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TIMEOUT) begin
        timeout_seconds <= cfg_data[TIME_W-1:0];
      end else if (cfg_index == REG_OFFLINE) begin
        offline_status <= cfg_data[STATUS_W-1:0];
      end
    end
  end

  // Program sequencer.
  clt_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .op       (op),
    .in_ready (in_ready)
  );

  // Table and result datapath.
  clt_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .in_valid        (in_valid),
    .client_id       (client_id),
    .client_status   (client_status),
    .now_time        (now_time),
    .timeout_seconds (timeout_seconds),
    .offline_status  (offline_status),
    .flags           (flags),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action          (action),
    .position        (position),
    .affected_id     (affected_id),
    .entry_count     (entry_count),
    .last_result     (last_result),
    .table_empty     (table_empty)
  );

endmodule

>>> tb/sv/client_liveness_table_tb.sv
// Self-checking testbench for client_liveness_table: directed and random messages
// are checked against a behavioral table model kept inside this file.
// Depends on clt_pkg and the client_liveness_table RTL.
module client_liveness_table_tb;
  import clt_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int POOL_SIZE = 24;
  localparam int IDLE_PERCENT = 35;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  // Register indexes past the end of the register list; writes there are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] count;
    logic             last;
    logic             empty;
  } liveness_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ID_W-1:0]       client_id = '0;
  logic [STATUS_W-1:0]   client_status = '0;
  logic [TIME_W-1:0]     now_time = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ACT_W-1:0]      action;
  logic [POS_W-1:0]      position;
  logic [ID_W-1:0]       affected_id;
  logic [POS_W-1:0]      entry_count;
  logic                  last_result;
  logic                  table_empty;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Model of the table and its registers.
  logic [ID_W-1:0]     known_ids [TABLE_DEPTH];
  logic [TIME_W-1:0]   heard_at [TABLE_DEPTH];
  int                  live_n;
  logic [TIME_W-1:0]   timeout_reg;
  logic [STATUS_W-1:0] offline_reg;

  liveness_result_t pending_results [$];
  liveness_result_t held;
  bit               have_held;
  liveness_result_t want;

  logic [ID_W-1:0]   id_pool [POOL_SIZE];
  logic [TIME_W-1:0] clock_now;
  bit                no_idle = 1'b0;
  int                mismatches = 0;
  int                cycle_count = 0;

  client_liveness_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .client_id(client_id), .client_status(client_status), .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .position(position), .affected_id(affected_id),
    .entry_count(entry_count), .last_result(last_result), .table_empty(table_empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Remove one entry and close the gap behind it.
  task automatic drop_slot(input int idx);
    int i;
    for (i = idx; i < live_n - 1; i++) begin
      known_ids[i] = known_ids[i + 1];
      heard_at[i] = heard_at[i + 1];
    end
    known_ids[live_n - 1] = '0;
    heard_at[live_n - 1] = '0;
    live_n--;
  endtask

  // The newest result is held back so that the final one can be marked as last.
  task automatic note_result(input logic [ACT_W-1:0] act, input int pos,
                             input logic [ID_W-1:0] id);
    if (have_held) pending_results.push_back(held);
    held.act = act;
    held.pos = POS_W'(pos);
    held.id = id;
    held.count = POS_W'(live_n);
    held.last = 1'b0;
    held.empty = (live_n == 0);
    have_held = 1'b1;
  endtask

  // Work out every result that one message causes and apply it to the table model.
  task automatic predict_message(input logic [ID_W-1:0] id,
                                 input logic [STATUS_W-1:0] status,
                                 input logic [TIME_W-1:0] now);
    int i;
    int hit;
    bit found;
    logic [TIME_W-1:0] age;
    logic [ID_W-1:0] gone;
    found = 1'b0;
    hit = 0;
    for (i = 0; i < live_n; i++) begin
      if (!found && known_ids[i] == id) begin
        found = 1'b1;
        hit = i;
      end
    end
    if (!found) begin
      if (live_n < TABLE_DEPTH) begin
        known_ids[live_n] = id;
        heard_at[live_n] = now;
        live_n++;
        note_result(ACT_ADDED, live_n, id);
      end else begin
        note_result(ACT_FULL, 0, id);
      end
    end else if (status == offline_reg) begin
      drop_slot(hit);
      note_result(ACT_OFFLINE, hit + 1, id);
    end else begin
      heard_at[hit] = now;
      note_result(ACT_UPDATED, hit + 1, id);
    end
    // Aging pass from the front; a removal leaves the index in place.
    i = 0;
    while (i < live_n) begin
      age = now - heard_at[i];
      if (age > timeout_reg) begin
        gone = known_ids[i];
        drop_slot(i);
        note_result(ACT_STALE, i + 1, gone);
      end else begin
        i++;
      end
    end
    held.last = 1'b1;
    pending_results.push_back(held);
    have_held = 1'b0;
  endtask

  // Present one message, with an optional random gap before it, and wait for acceptance.
  task automatic send_message(input logic [ID_W-1:0] id, input logic [STATUS_W-1:0] status,
                              input logic [TIME_W-1:0] now);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    client_id <= id;
    client_status <= status;
    now_time <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_message(id, status, now);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TIMEOUT) timeout_reg = data;
    else if (idx == REG_OFFLINE) offline_reg = data[STATUS_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Adding, refreshing and going offline under the reset register values.
  task automatic test_add_update_offline();
    send_message(32'h0000_0000, 3'd0, 32'd1000);
    send_message(32'hFFFF_FFFF, 3'd7, 32'd1000);
    send_message(32'h0000_0000, 3'd1, 32'd1010);
    // An unknown id carrying the offline status is still added.
    send_message(32'h1234_5678, OFFLINE_RESET, 32'd1010);
    send_message(32'hFFFF_FFFF, OFFLINE_RESET, 32'd1020);
    send_message(32'h0000_0000, OFFLINE_RESET, 32'd1020);
    send_message(32'h1234_5678, OFFLINE_RESET, 32'd1020);
  endtask

  // An age equal to the timeout survives, one more second does not; time may wrap.
  task automatic test_age_boundary_and_wrap();
    send_message(32'd10, 3'd2, 32'd2000);
    send_message(32'd11, 3'd3, 32'd2035);
    send_message(32'd11, 3'd3, 32'd2036);
    send_message(32'd12, 3'd0, 32'd2000);
    send_message(32'd12, 3'd5, 32'hFFFF_FFF0);
    send_message(32'd13, 3'd4, 32'h0000_0010);
  endtask

  // Fill the table, then reject a new id and age every entry out in one burst.
  task automatic test_full_table_burst();
    int k;
    wait_results_drained();
    write_reg(REG_TIMEOUT, '1);
    k = 0;
    while (live_n < TABLE_DEPTH) begin
      send_message(32'h0000_0100 + ID_W'(k), 3'(k), 32'h0000_0020);
      k++;
    end
    wait_results_drained();
    write_reg(REG_TIMEOUT, '0);
    send_message(32'h5A5A_A5A5, 3'd1, 32'h0000_0021);
  endtask

  // Writes past the register list must leave both registers alone.
  task automatic test_ignored_indexes();
    wait_results_drained();
    write_reg(REG_UNUSED_LOW, $urandom);
    write_reg(REG_UNUSED_TOP, $urandom);
  endtask

  // Mostly messages from a small set of clients with a slowly moving clock, plus noise.
  task automatic test_random_traffic(input logic [TIME_W-1:0] timeout,
                                     input logic [STATUS_W-1:0] offline, input bit quiet);
    int n;
    int r;
    logic [ID_W-1:0] id;
    logic [STATUS_W-1:0] st;
    wait_results_drained();
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_OFFLINE, CFG_DATA_W'(offline));
    no_idle = quiet;
    for (n = 0; n < ITEMS_PER_PHASE; n++) begin
      if ($urandom_range(99) < 15) begin
        send_message($urandom, 3'($urandom_range(7)), $urandom);
      end else begin
        id = id_pool[$urandom_range(POOL_SIZE - 1)];
        st = ($urandom_range(99) < 20) ? offline_reg : 3'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 75) clock_now = clock_now + TIME_W'($urandom_range(8));
        else if (r < 88) clock_now = clock_now + TIME_W'($urandom_range(60));
        else if (r < 95) clock_now = clock_now - TIME_W'($urandom_range(50, 1));
        else clock_now = $urandom;
        send_message(id, st, clock_now);
      end
    end
    no_idle = 1'b0;
  endtask

  // The receiver stalls at random unless a no-idle stretch is running.
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Check each accepted result against the oldest expectation; guard the run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result item: action %0d position %0d id %h", action,
                   position, affected_id);
      end else begin
        want = pending_results.pop_front();
        if (action !== want.act || position !== want.pos || affected_id !== want.id ||
            entry_count !== want.count || last_result !== want.last ||
            table_empty !== want.empty) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected act %0d pos %0d id %h count %0d last %0d empty %0d",
                     want.act, want.pos, want.id, want.count, want.last, want.empty);
            $display("          actual   act %0d pos %0d id %h count %0d last %0d empty %0d",
                     action, position, affected_id, entry_count, last_result, table_empty);
          end
        end
      end
    end
  end

  // Test sequence.
  initial begin
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      known_ids[i] = '0;
      heard_at[i] = '0;
    end
    live_n = 0;
    timeout_reg = TIMEOUT_RESET;
    offline_reg = OFFLINE_RESET;
    have_held = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    clock_now = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_add_update_offline();
    test_age_boundary_and_wrap();
    test_full_table_burst();
    test_ignored_indexes();
    test_random_traffic(TIMEOUT_RESET, OFFLINE_RESET, 1'b0);
    test_random_traffic('0, '0, 1'b0);
    test_random_traffic('1, '1, 1'b1);
    test_random_traffic(TIME_W'($urandom_range(60, 5)), 3'($urandom_range(7)), 1'b0);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/clt_pkg.sv
rtl/clt_useq.sv
rtl/clt_datapath.sv
rtl/client_liveness_table.sv
tb/sv/client_liveness_table_tb.sv
